### rtl/framed_stream_replay_filter_assert.svh
// assertion macros used by the rtl of the replay filter
`ifndef FRAMED_STREAM_REPLAY_FILTER_ASSERT_SVH
`define FRAMED_STREAM_REPLAY_FILTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FSRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FSRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fsrf_pkg.sv
// shared types and constants of the replay filter
`default_nettype none
package fsrf_pkg;

    localparam int BYTE_W    = 8;
    localparam int PAYLOAD_W = 7;

    typedef struct packed {
        logic shift;
        logic load;
        logic drain;
    } t_cell_ctl;

endpackage
`default_nettype wire

### rtl/fsrf_cell.sv
// one window cell: a received byte slot and a shadow slot for frame replay
`default_nettype none
module fsrf_cell #(
    parameter bit IS_DATA = 1'b0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire fsrf_pkg::t_cell_ctl          i_ctl,
    input  wire logic [fsrf_pkg::BYTE_W-1:0]  i_win,
    input  wire logic [fsrf_pkg::BYTE_W-1:0]  i_shd,
    output logic      [fsrf_pkg::BYTE_W-1:0]  o_win,
    output logic      [fsrf_pkg::BYTE_W-1:0]  o_shd
);

    logic [fsrf_pkg::BYTE_W-1:0] r_win, n_win;
    logic [fsrf_pkg::BYTE_W-1:0] r_shd, n_shd;

    always_comb begin
        n_win = i_ctl.shift ? i_win : r_win;
        n_shd = r_shd;
        if (i_ctl.load) begin
            n_shd = IS_DATA ? {1'b0, r_win[fsrf_pkg::PAYLOAD_W-1:0]} : r_win;
        end else if (i_ctl.drain) begin
            n_shd = i_shd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shd <= n_shd;
    end

    assign o_win = r_win;
    assign o_shd = r_shd;

endmodule
`default_nettype wire

### rtl/framed_stream_replay_filter.sv
// top level of the framed stream replay filter
//
//   channel  direction  valid    stall    payload
//   rx       in         i_valid  o_stall  i_rx_byte
//   tx       out        o_valid  i_stall  o_tx_byte, o_frame_end
//
// a byte enters the cell chain in the cycle of its transfer; the frame check runs the cycle after
// non-frame bytes are taken one per cycle while no frame holds rx, the check overlapping the next byte
// a frame blocks rx from its check until MSG_BYTES-1 tx transfers from the shadow chain are done
// tx stalls hold the shadow chain, and rx too while a frame holds it; a pending frame check waits for the chain to free
// reset clears the window cells, the check flag, the tx count and the replay state
`default_nettype none
`include "framed_stream_replay_filter_assert.svh"
module framed_stream_replay_filter #(
    parameter int MSG_BYTES  = 16,
    parameter int DATA_BYTES = 8,
    parameter int HEADER_END = 12,
    parameter int SEQ_BYTES  = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [fsrf_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [fsrf_pkg::BYTE_W-1:0]  o_tx_byte,
    output logic                              o_frame_end
);

    localparam int SEQ_N = (SEQ_BYTES < MSG_BYTES) ? SEQ_BYTES : MSG_BYTES;
    localparam int SEQ_W = fsrf_pkg::PAYLOAD_W * SEQ_N;
    localparam int CNT_W = $clog2(MSG_BYTES + 1);

    logic [fsrf_pkg::BYTE_W-1:0] w_win [MSG_BYTES];
    logic [fsrf_pkg::BYTE_W-1:0] w_shd [MSG_BYTES];
    logic [MSG_BYTES-1:0]        w_bad;
    logic [SEQ_W-1:0]            w_seq;
    fsrf_pkg::t_cell_ctl         w_ctl;

    logic             r_chk, n_chk;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_seen, n_seen;
    logic [SEQ_W-1:0] r_last_seq, n_last_seq;

    logic in_xfer, out_xfer, match, shd_free, fire;

    genvar gi;
    generate
        for (gi = 0; gi < MSG_BYTES; gi++) begin : g_cell
            localparam bit IS_DATA = (gi < DATA_BYTES);
            localparam bit IS_HDR  = (gi >= DATA_BYTES) && (gi < HEADER_END);
            logic [fsrf_pkg::BYTE_W-1:0] win_in;
            logic [fsrf_pkg::BYTE_W-1:0] shd_in;

            if (gi == 0) begin : g_head
                assign win_in = i_rx_byte;
            end else begin : g_body
                assign win_in = w_win[gi-1];
            end
            if (gi == MSG_BYTES - 1) begin : g_tail
                assign shd_in = '0;
            end else begin : g_link
                assign shd_in = w_shd[gi+1];
            end

            fsrf_cell #(
                .IS_DATA (IS_DATA)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_win   (win_in),
                .i_shd   (shd_in),
                .o_win   (w_win[gi]),
                .o_shd   (w_shd[gi])
            );

            assign w_bad[gi] = (IS_DATA && w_win[gi][fsrf_pkg::BYTE_W-1])
                            || (IS_HDR && !w_win[gi][fsrf_pkg::BYTE_W-1]);
        end

        for (gi = 0; gi < SEQ_N; gi++) begin : g_seq
            assign w_seq[gi*fsrf_pkg::PAYLOAD_W +: fsrf_pkg::PAYLOAD_W] =
                w_win[MSG_BYTES-1-gi][fsrf_pkg::PAYLOAD_W-1:0];
        end
    endgenerate

    assign match    = r_chk && !(|w_bad) && (!r_seen || (w_seq > r_last_seq));
    assign o_valid  = (r_cnt != '0);
    assign out_xfer = o_valid && !i_stall;
    assign shd_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && out_xfer);
    assign fire     = match && shd_free;
    assign o_stall  = (r_cnt > CNT_W'(1)) || match;
    assign in_xfer  = i_valid && !o_stall;

    assign w_ctl.shift = in_xfer;
    assign w_ctl.load  = fire;
    assign w_ctl.drain = out_xfer;

    assign o_tx_byte   = w_shd[0];
    assign o_frame_end = (r_cnt == CNT_W'(1));

    always_comb begin
        n_chk      = in_xfer || (match && !shd_free);
        n_cnt      = r_cnt;
        n_seen     = r_seen;
        n_last_seq = r_last_seq;
        if (fire) begin
            n_cnt      = CNT_W'(MSG_BYTES);
            n_seen     = 1'b1;
            n_last_seq = w_seq;
        end else if (out_xfer) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk      <= 1'b0;
            r_cnt      <= '0;
            r_seen     <= 1'b0;
            r_last_seq <= '0;
        end else begin
            r_chk      <= n_chk;
            r_cnt      <= n_cnt;
            r_seen     <= n_seen;
            r_last_seq <= n_last_seq;
        end
    end

    `FSRF_ASSERT_NXT(a_fire_loads, fire, o_valid && (r_cnt == CNT_W'(MSG_BYTES)), "frame not loaded")
    `FSRF_ASSERT_NXT(a_seq_kept, fire, r_seen && (r_last_seq == $past(w_seq)), "sequence not stored")
    `FSRF_ASSERT_NXT(a_chk_after_rx, in_xfer, r_chk, "received byte not checked")
    `FSRF_ASSERT_NXT(a_end_drains, out_xfer && o_frame_end && !fire, !o_valid, "extra transfer")
    `FSRF_ASSERT_NOW(a_no_rx_busy, in_xfer, (r_cnt <= CNT_W'(1)) && !match, "rx taken while busy")

endmodule
`default_nettype wire
